// ===== design/cnrs_pkg.sv =====
// Package: shared types and constants for the cubic Newton root solver.
`default_nettype none
package cnrs_pkg;
	localparam int QW = 32;
	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;
	localparam logic [1:0] ST_REAL    = 2'd0;
	localparam logic [1:0] ST_COMPLEX = 2'd1;
	localparam logic [1:0] ST_LEAD0   = 2'd2;

	typedef struct packed {
		logic [1:0]            status;
		logic signed [QW-1:0]  minus_root;
		logic signed [QW-1:0]  plus_root;
		logic signed [QW-1:0]  newton_root;
	} result_t;

	function automatic logic signed [QW-1:0] sat_w(input logic signed [QW+3:0] x);
		if (x > 36'(Q_MAX)) return Q_MAX;
		else if (x < 36'(Q_MIN)) return Q_MIN;
		else return x[QW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/cubic_newton_root_solver_core.sv =====
// Top level: cubic solver with Newton iteration, deflation and quadratic formula.
// Usage notes:
//  s_axis carries one request: eight signed Q16.16 coefficients in tdata,
//  left cube, square, linear, constant, then the right side, lowest bits first.
//  m_axis returns newton_root, plus_root, minus_root, status in tdata.
//  cfg writes the 31-bit tolerance; accepted only while idle (reset 66).
//  One request is processed at a time; s_axis_tready is low while busy.
//  One shared 32x32 multiplier, a shared 64/32 restoring divider (one quotient
//  bit per cycle) and a two-bit-per-cycle square root carry all the work.
//  Most of each Newton step is spent in the divider; a step takes longer when
//  f' is zero and the guess is nudged before the division.
//  After reset the block is idle with tolerance 66. When the receiver stalls
//  the result is held in the output register; the next request is taken
//  once the result has been delivered.
`default_nettype none
module cubic_newton_root_solver_core #(
	parameter int MAX_ITERATIONS = 100,
	parameter int FRACTION_BITS  = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// lc3, lc2, lc1, lc0, rc3, rc2, rc1, rc0 (32 bits each, low first)
	input  wire logic [255:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// newton_root, plus_root, minus_root (32 each), status (2), zero pad
	output logic [103:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [30:0]  cfg_data
);
	import cnrs_pkg::*;

	localparam int CW = $clog2(MAX_ITERATIONS + 2);
	localparam logic signed [QW-1:0] START_G = QW'(((64'sd1 <<< FRACTION_BITS) + 50) / 100);
	localparam logic signed [QW-1:0] NUDGE = QW'(((64'sd1 <<< FRACTION_BITS) + 500) / 1000);

	typedef enum logic [4:0] {
		S_IDLE, S_F1, S_F2, S_F3, S_FCHK, S_D1, S_D2, S_DCHK, S_D2B, S_DV1,
		S_DIV, S_GUP, S_BP, S_BPM, S_CP, S_CPM, S_DISC1, S_DISC2, S_SQRT,
		S_FIN, S_OUT
	} state_t;

	typedef enum logic [1:0] {DV_STEP, DV_BP, DV_CP} dvuse_t;

	state_t state_q;
	dvuse_t dvuse_q;
	logic signed [QW-1:0] a_q, b_q, c_q, d_q, g_q, f_q, t_q, bp_q, cp_q;
	logic [30:0] tol_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] sub_q;
	logic pass2_q;
	result_t res_q;

	// shared multiplier
	logic signed [QW-1:0] mx, my;
	logic signed [63:0] prod;
	logic signed [QW-1:0] mq;
	always_comb begin
		mx = t_q; my = g_q;
		unique case (state_q)
			S_CPM: begin mx = bp_q; my = g_q; end
			S_DISC1: begin mx = bp_q; my = bp_q; end
			default: begin mx = t_q; my = g_q; end
		endcase
	end
	assign prod = mx * my;
	always_comb begin
		logic signed [63:0] sh;
		sh = prod >>> FRACTION_BITS;
		if (sh > 64'(Q_MAX)) mq = Q_MAX;
		else if (sh < 64'(Q_MIN)) mq = Q_MIN;
		else mq = sh[QW-1:0];
	end

	// divider: |n|<<FB / |d|, truncating
	logic [63:0] dv_num_q, dv_rem_q;
	logic [31:0] dv_den_q;
	logic [63:0] dv_quo_q;
	logic dv_neg_q;
	logic [6:0] dv_cnt_q;
	logic [64:0] dv_try;
	assign dv_try = {dv_rem_q, dv_num_q[63]} - {33'd0, dv_den_q};

	logic signed [QW-1:0] dv_res;
	always_comb begin
		logic signed [64:0] sq;
		sq = dv_neg_q ? -$signed({1'b0, dv_quo_q}) : $signed({1'b0, dv_quo_q});
		if (sq > 65'(Q_MAX)) dv_res = Q_MAX;
		else if (sq < 65'(Q_MIN)) dv_res = Q_MIN;
		else dv_res = sq[QW-1:0];
	end

	// sqrt
	logic [63:0] sv_q, sres_q, sbit_q;
	logic signed [63:0] disc_q;

	logic signed [QW-1:0] fabs;
	assign fabs = f_q;
	logic [32:0] fmag;
	assign fmag = fabs[QW-1] ? 33'(-$signed({fabs[QW-1], fabs})) : {1'b0, fabs};

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {6'd0, res_q.status, res_q.minus_root, res_q.plus_root,
		res_q.newton_root};

	function automatic logic signed [QW-1:0] ssub(input logic [31:0] x, input logic [31:0] y);
		return sat_w(36'($signed(x)) - 36'($signed(y)));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= 31'd66;
			cnt_q <= '0;
			dvuse_q <= DV_STEP;
			pass2_q <= 1'b0;
			sub_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) tol_q <= cfg_data;
					if (s_axis_tvalid) begin
						a_q <= ssub(s_axis_tdata[31:0], s_axis_tdata[159:128]);
						b_q <= ssub(s_axis_tdata[63:32], s_axis_tdata[191:160]);
						c_q <= ssub(s_axis_tdata[95:64], s_axis_tdata[223:192]);
						d_q <= ssub(s_axis_tdata[127:96], s_axis_tdata[255:224]);
						g_q <= START_G;
						cnt_q <= CW'(1);
						pass2_q <= 1'b0;
						state_q <= S_F1;
					end
				end
				S_F1: begin t_q <= a_q; state_q <= S_F2; sub_q <= 2'd0; end
				S_F2: begin
					// Horner: t = sat(mq(t,g) + coef)
					unique case (sub_q)
						2'd0: t_q <= sat_w(36'(mq) + 36'(b_q));
						2'd1: t_q <= sat_w(36'(mq) + 36'(c_q));
						default: t_q <= sat_w(36'(mq) + 36'(d_q));
					endcase
					if (sub_q == 2'd2) state_q <= S_F3;
					sub_q <= sub_q + 2'd1;
				end
				S_F3: begin
					f_q <= t_q;
					state_q <= pass2_q ? S_DV1 : S_FCHK;
				end
				S_FCHK: begin
					if (fmag <= {2'b0, tol_q} || int'(cnt_q) > MAX_ITERATIONS) begin
						state_q <= S_BP;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						t_q <= a_q;
						sub_q <= 2'd0;
						state_q <= S_D1;
					end
				end
				S_D1: begin
					// t = sat(3*mq(a,g) + 2b)
					t_q <= sat_w(36'(mq) * 36'sd3 + 36'(b_q) * 36'sd2);
					state_q <= S_D2;
				end
				S_D2: begin
					t_q <= sat_w(36'(mq) + 36'(c_q));
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (t_q == '0 && sub_q == 2'd0) begin
						g_q <= sat_w(36'(g_q) + 36'(NUDGE));
						t_q <= a_q;
						sub_q <= 2'd1;
						state_q <= S_D1;
					end else if (t_q == '0) begin
						state_q <= S_F1;
					end else begin
						bp_q <= t_q; // df
						pass2_q <= 1'b1;
						state_q <= S_F1;
					end
				end
				S_DV1: begin
					pass2_q <= 1'b0;
					dvuse_q <= DV_STEP;
					dv_neg_q <= f_q[QW-1] ^ bp_q[QW-1];
					dv_num_q <= 64'(f_q[QW-1] ? 33'(-$signed({1'b1, f_q})) : 33'(f_q))
						<< FRACTION_BITS;
					dv_den_q <= bp_q[QW-1] ? 32'(-$signed({1'b1, bp_q})) : bp_q;
					dv_rem_q <= '0;
					dv_quo_q <= '0;
					dv_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!dv_try[64]) begin
						dv_rem_q <= dv_try[63:0];
						dv_quo_q <= {dv_quo_q[62:0], 1'b1};
					end else begin
						dv_rem_q <= {dv_rem_q[62:0], dv_num_q[63]};
						dv_quo_q <= {dv_quo_q[62:0], 1'b0};
					end
					dv_num_q <= {dv_num_q[62:0], 1'b0};
					dv_cnt_q <= dv_cnt_q + 7'd1;
					if (dv_cnt_q == 7'd63) state_q <= S_GUP;
				end
				S_GUP: begin
					unique case (dvuse_q)
						DV_STEP: begin
							g_q <= sat_w(36'(g_q) - 36'(dv_res));
							state_q <= S_F1;
						end
						DV_BP: begin
							bp_q <= sat_w(36'(dv_res) + 36'(g_q));
							state_q <= S_CP;
						end
						default: begin
							cp_q <= dv_res;
							state_q <= S_CPM;
						end
					endcase
				end
				S_BP: begin
					if (a_q == '0) begin
						res_q <= '{status: ST_LEAD0, minus_root: '0, plus_root: '0,
							newton_root: g_q};
						state_q <= S_OUT;
					end else begin
						dvuse_q <= DV_BP;
						dv_neg_q <= b_q[QW-1] ^ a_q[QW-1];
						dv_num_q <= 64'(b_q[QW-1] ? 33'(-$signed({1'b1, b_q})) : 33'(b_q))
							<< FRACTION_BITS;
						dv_den_q <= a_q[QW-1] ? 32'(-$signed({1'b1, a_q})) : a_q;
						dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_CP: begin
					dvuse_q <= DV_CP;
					dv_neg_q <= c_q[QW-1] ^ a_q[QW-1];
					dv_num_q <= 64'(c_q[QW-1] ? 33'(-$signed({1'b1, c_q})) : 33'(c_q))
						<< FRACTION_BITS;
					dv_den_q <= a_q[QW-1] ? 32'(-$signed({1'b1, a_q})) : a_q;
					dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_CPM: begin
					cp_q <= sat_w(36'(cp_q) + 36'(mq));
					state_q <= S_DISC1;
				end
				S_DISC1: begin
					disc_q <= prod;
					state_q <= S_DISC2;
				end
				S_DISC2: begin
					if (disc_q - (64'(cp_q) <<< (FRACTION_BITS + 2)) < 0) begin
						res_q <= '{status: ST_COMPLEX, minus_root: '0, plus_root: '0,
							newton_root: g_q};
						state_q <= S_OUT;
					end else begin
						sv_q <= disc_q - (64'(cp_q) <<< (FRACTION_BITS + 2));
						sres_q <= '0;
						sbit_q <= 64'd1 << 62;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sbit_q == '0) begin
						state_q <= S_FIN;
					end else begin
						if (sv_q >= sres_q + sbit_q) begin
							sv_q <= sv_q - (sres_q + sbit_q);
							sres_q <= (sres_q >> 1) + sbit_q;
						end else begin
							sres_q <= sres_q >> 1;
						end
						sbit_q <= sbit_q >> 2;
					end
				end
				S_FIN: begin
					res_q.newton_root <= g_q;
					res_q.status <= ST_REAL;
					res_q.plus_root <= sat_w(36'(($signed({2'b0, sres_q[32:0]})
						- 36'(bp_q)) >>> 1));
					res_q.minus_root <= sat_w(36'((-36'(bp_q)
						- $signed({2'b0, sres_q[32:0]})) >>> 1));
					state_q <= S_OUT;
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_F1;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[97:96] != 2'd3);
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_ITERATIONS + 1);
endmodule
`default_nettype wire
